// ===== src/ascp_pkg.sv =====
// shared types, constants and helper functions of the ascii can command parser
package ascp_pkg;

    localparam int LINE_CAPACITY_DEF = 32;
    localparam int SCAN_MAX = 25;

    localparam logic [7:0] EOL_RESET = 8'd13;
    localparam logic [7:0] ERR_RESET = 8'd7;
    localparam logic [3:0] BITRATE_RESET = 4'd6;

    localparam logic REG_END_LINE = 1'b0;
    localparam logic REG_ERROR = 1'b1;

    localparam logic [1:0] KIND_REPLY = 2'd0;
    localparam logic [1:0] KIND_FRAME = 2'd1;
    localparam logic [1:0] KIND_OPEN = 2'd2;
    localparam logic [1:0] KIND_CLOSE = 2'd3;

    localparam logic [2:0] MODE_ERR = 3'd0;
    localparam logic [2:0] MODE_CLOSE = 3'd1;
    localparam logic [2:0] MODE_OPEN = 3'd2;
    localparam logic [2:0] MODE_ACK = 3'd3;
    localparam logic [2:0] MODE_LETTER = 3'd4;
    localparam logic [2:0] MODE_STAT = 3'd5;
    localparam logic [2:0] MODE_FRAME = 3'd6;

    localparam logic [1:0] OPEN_NORMAL = 2'd0;
    localparam logic [1:0] OPEN_LISTEN = 2'd1;
    localparam logic [1:0] OPEN_LOOPBACK = 2'd2;

    localparam logic [7:0] CH_C = "C";
    localparam logic [7:0] CH_O = "O";
    localparam logic [7:0] CH_L = "L";
    localparam logic [7:0] CH_LL = "l";
    localparam logic [7:0] CH_S = "S";
    localparam logic [7:0] CH_F = "F";
    localparam logic [7:0] CH_V = "V";
    localparam logic [7:0] CH_VL = "v";
    localparam logic [7:0] CH_N = "N";
    localparam logic [7:0] CH_T = "T";
    localparam logic [7:0] CH_TL = "t";
    localparam logic [7:0] CH_R = "R";
    localparam logic [7:0] CH_RL = "r";
    localparam logic [7:0] CH_0 = "0";
    localparam logic [7:0] CH_8 = "8";

    typedef struct packed {
        logic       accept;
        logic       rd;
        logic       decide;
        logic       load;
        logic [1:0] idx;
    } ascp_cmd_t;

    typedef struct packed {
        logic is_eol;
        logic len_zero;
        logic full;
        logic scan_end;
        logic out_busy;
        logic res_last;
    } ascp_stat_t;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= "0" && c <= "9") v = c[3:0];
        else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) v = c[3:0] + 4'd9;
        return v;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] c;
        if (v < 4'd10) c = 8'h30 + {4'd0, v};
        else c = 8'h37 + {4'd0, v};
        return c;
    endfunction

endpackage

// ===== src/ascp_ctrl.sv =====
// controller state machine: accept, line scan, decode and result sequencing
module ascp_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  ascp_pkg::ascp_stat_t  stat,
    output ascp_pkg::ascp_cmd_t   cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [1:0] idx_reg, idx_next;

    always_comb begin
        state_next = state_reg;
        idx_next = idx_reg;
        cmd = '0;
        cmd.idx = idx_reg;
        s_tready = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE: begin
                idx_next = 2'd0;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    if (stat.is_eol) begin
                        state_next = stat.len_zero ? ST_EMIT : ST_SCAN;
                    end else if (stat.full) begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_SCAN: begin
                cmd.rd = 1'b1;
                if (stat.scan_end) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!stat.out_busy) begin
                    cmd.load = 1'b1;
                    if (stat.res_last) state_next = ST_IDLE;
                    else idx_next = idx_reg + 2'd1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg <= 2'd0;
        end else begin
            state_reg <= state_next;
            idx_reg <= idx_next;
        end
    end

endmodule

// ===== src/ascp_datapath.sv =====
// datapath: line buffer, configuration, frame decode and output register
module ascp_datapath #(
    parameter int LINE_CAPACITY = ascp_pkg::LINE_CAPACITY_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [7:0]           rx_byte,
    input  logic                 sink_ok,
    input  logic [7:0]           controller_status,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [7:0]           cfg_data,
    input  ascp_pkg::ascp_cmd_t  cmd,
    output ascp_pkg::ascp_stat_t stat,
    input  logic                 m_accept,
    output logic                 m_valid,
    output logic [1:0]           out_kind,
    output logic [7:0]           reply_byte,
    output logic [28:0]          frame_id,
    output logic                 frame_extended,
    output logic                 frame_remote,
    output logic [3:0]           frame_dlc,
    output logic [63:0]          frame_data,
    output logic [1:0]           open_mode,
    output logic [3:0]           open_bitrate,
    output logic                 last
);

    localparam int AW = $clog2(LINE_CAPACITY);
    localparam int LW = $clog2(LINE_CAPACITY + 1);
    localparam logic [LW-1:0] LEN_CAP = LW'(LINE_CAPACITY);

    logic [7:0]    mem [LINE_CAPACITY];
    logic [7:0]    eol_reg, err_reg;
    logic [3:0]    bitrate_reg;
    logic [LW-1:0] len_reg;
    logic [LW-1:0] len_inc, len_m1;
    logic          ok_reg;
    logic [7:0]    status_reg;
    logic [AW-1:0] pos_reg, scan_last;
    logic [7:0]    data_reg;
    logic [4:0]    dpos_reg;
    logic          dvalid_reg;
    logic [7:0]    cmd_char_reg, sdig_reg;
    logic [28:0]   id_reg;
    logic [3:0]    dlc_reg;
    logic [63:0]   fdata_reg;
    logic [2:0]    mode_reg, mode_next;
    logic          m_valid_reg;

    logic [3:0]    nib;
    logic          ext, rem, frame_ok, s_ok;
    logic [4:0]    head, jpos;
    logic [6:0]    len7, head7, need7;
    logic [63:0]   keep;
    logic [1:0]    cnt_m1;

    logic [1:0]    kind_r;
    logic [7:0]    reply_r;
    logic [1:0]    omode_r;
    logic          last_r;

    assign len_inc = len_reg + LW'(1);
    assign len_m1 = len_reg - LW'(1);
    assign scan_last = (len_m1 > LW'(ascp_pkg::SCAN_MAX)) ? AW'(ascp_pkg::SCAN_MAX)
                                                          : len_m1[AW-1:0];

    assign stat.is_eol = (rx_byte == eol_reg);
    assign stat.len_zero = (len_reg == '0);
    assign stat.full = (len_inc == LEN_CAP);
    assign stat.scan_end = (pos_reg == scan_last);
    assign stat.out_busy = m_valid_reg;
    assign stat.res_last = (cmd.idx == cnt_m1);

    // character decode
    assign nib = ascp_pkg::hex_value(data_reg);
    assign ext = (cmd_char_reg == ascp_pkg::CH_T) || (cmd_char_reg == ascp_pkg::CH_R);
    assign rem = (cmd_char_reg == ascp_pkg::CH_RL) || (cmd_char_reg == ascp_pkg::CH_R);
    assign head = ext ? 5'd10 : 5'd5;
    assign jpos = dpos_reg - head;

    // line checks
    assign len7 = 7'(len_reg);
    assign head7 = {2'd0, head};
    assign need7 = head7 + {2'd0, dlc_reg, 1'b0};
    assign frame_ok = (len7 >= head7) && (dlc_reg <= 4'd8) && (rem || (len7 >= need7));
    assign s_ok = (len7 >= 7'd2) && (sdig_reg >= ascp_pkg::CH_0) && (sdig_reg <= ascp_pkg::CH_8);
    assign keep = ~(64'hFFFF_FFFF_FFFF_FFFF >> {dlc_reg, 3'b000});

    always_comb begin
        case (cmd_char_reg)
            ascp_pkg::CH_C: mode_next = ok_reg ? ascp_pkg::MODE_CLOSE : ascp_pkg::MODE_ERR;
            ascp_pkg::CH_O, ascp_pkg::CH_L, ascp_pkg::CH_LL:
                mode_next = ok_reg ? ascp_pkg::MODE_OPEN : ascp_pkg::MODE_ERR;
            ascp_pkg::CH_S: mode_next = s_ok ? ascp_pkg::MODE_ACK : ascp_pkg::MODE_ERR;
            ascp_pkg::CH_V, ascp_pkg::CH_VL, ascp_pkg::CH_N: mode_next = ascp_pkg::MODE_LETTER;
            ascp_pkg::CH_F: mode_next = ascp_pkg::MODE_STAT;
            ascp_pkg::CH_T, ascp_pkg::CH_TL, ascp_pkg::CH_R, ascp_pkg::CH_RL:
                mode_next = (ok_reg && frame_ok) ? ascp_pkg::MODE_FRAME : ascp_pkg::MODE_ERR;
            default: mode_next = ascp_pkg::MODE_ERR;
        endcase
    end

    always_comb begin
        case (cmd_char_reg)
            ascp_pkg::CH_L: omode_r = ascp_pkg::OPEN_LISTEN;
            ascp_pkg::CH_LL: omode_r = ascp_pkg::OPEN_LOOPBACK;
            default: omode_r = ascp_pkg::OPEN_NORMAL;
        endcase
    end

    // result selection by index
    always_comb begin
        kind_r = ascp_pkg::KIND_REPLY;
        reply_r = eol_reg;
        cnt_m1 = 2'd1;
        case (mode_reg)
            ascp_pkg::MODE_ERR: begin
                reply_r = err_reg;
                cnt_m1 = 2'd0;
            end
            ascp_pkg::MODE_CLOSE: begin
                if (cmd.idx == 2'd0) begin
                    kind_r = ascp_pkg::KIND_CLOSE;
                    reply_r = 8'd0;
                end
            end
            ascp_pkg::MODE_OPEN: begin
                if (cmd.idx == 2'd0) begin
                    kind_r = ascp_pkg::KIND_OPEN;
                    reply_r = 8'd0;
                end
            end
            ascp_pkg::MODE_ACK: begin
                cnt_m1 = 2'd0;
            end
            ascp_pkg::MODE_LETTER: begin
                if (cmd.idx == 2'd0) reply_r = cmd_char_reg;
            end
            ascp_pkg::MODE_STAT: begin
                cnt_m1 = 2'd3;
                case (cmd.idx)
                    2'd0: reply_r = ascp_pkg::CH_F;
                    2'd1: reply_r = ascp_pkg::hex_char(status_reg[7:4]);
                    2'd2: reply_r = ascp_pkg::hex_char(status_reg[3:0]);
                    default: reply_r = eol_reg;
                endcase
            end
            ascp_pkg::MODE_FRAME: begin
                kind_r = ascp_pkg::KIND_FRAME;
                reply_r = 8'd0;
                cnt_m1 = 2'd0;
            end
            default: begin
                reply_r = err_reg;
                cnt_m1 = 2'd0;
            end
        endcase
        last_r = (cmd.idx == cnt_m1);
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && !stat.is_eol) mem[len_reg[AW-1:0]] <= rx_byte;
        if (cmd.rd) data_reg <= mem[pos_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eol_reg <= ascp_pkg::EOL_RESET;
            err_reg <= ascp_pkg::ERR_RESET;
            bitrate_reg <= ascp_pkg::BITRATE_RESET;
            len_reg <= '0;
            dvalid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    ascp_pkg::REG_END_LINE: eol_reg <= cfg_data;
                    ascp_pkg::REG_ERROR: err_reg <= cfg_data;
                    default: eol_reg <= eol_reg;
                endcase
            end
            if (cmd.accept && !stat.is_eol) len_reg <= stat.full ? '0 : len_inc;
            if (cmd.decide) begin
                len_reg <= '0;
                if (cmd_char_reg == ascp_pkg::CH_S && s_ok) bitrate_reg <= sdig_reg[3:0];
            end
            dvalid_reg <= cmd.rd;
            if (cmd.load) m_valid_reg <= 1'b1;
            else if (m_accept) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            ok_reg <= sink_ok;
            status_reg <= controller_status;
            pos_reg <= '0;
            if (!stat.is_eol ? stat.full : stat.len_zero) mode_reg <= ascp_pkg::MODE_ERR;
        end
        if (cmd.rd) begin
            pos_reg <= pos_reg + AW'(1);
            dpos_reg <= 5'(pos_reg);
        end
        if (dvalid_reg) begin
            if (dpos_reg == 5'd0) begin
                cmd_char_reg <= data_reg;
                fdata_reg <= '0;
            end else if (dpos_reg == 5'd1) begin
                sdig_reg <= data_reg;
                id_reg <= ext ? {28'd0, nib[0]} : {26'd0, nib[2:0]};
            end else if (dpos_reg < head - 5'd1) begin
                id_reg <= {id_reg[24:0], nib};
            end else if (dpos_reg == head - 5'd1) begin
                dlc_reg <= nib;
            end else if (jpos < 5'd16) begin
                fdata_reg[{~jpos[3:0], 2'b00} +: 4] <= nib;
            end
        end
        if (cmd.decide) begin
            mode_reg <= mode_next;
            fdata_reg <= rem ? 64'd0 : (fdata_reg & keep);
        end
        if (cmd.load) begin
            out_kind <= kind_r;
            reply_byte <= reply_r;
            last <= last_r;
            frame_id <= (kind_r == ascp_pkg::KIND_FRAME) ? id_reg : 29'd0;
            frame_extended <= (kind_r == ascp_pkg::KIND_FRAME) && ext;
            frame_remote <= (kind_r == ascp_pkg::KIND_FRAME) && rem;
            frame_dlc <= (kind_r == ascp_pkg::KIND_FRAME) ? dlc_reg : 4'd0;
            frame_data <= (kind_r == ascp_pkg::KIND_FRAME) ? fdata_reg : 64'd0;
            open_mode <= (kind_r == ascp_pkg::KIND_OPEN) ? omode_r : 2'd0;
            open_bitrate <= (kind_r == ascp_pkg::KIND_OPEN) ? bitrate_reg : 4'd0;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== src/ascii_can_command_line_parser.sv =====
// top level of the ascii can adapter command line parser
//
// Host characters enter on the s_ stream, one per transfer, together with the
// current sink_ok flag and controller status byte. Results leave on the m_
// stream: m_tuser carries the result kind (reply byte, frame, open, close) and
// m_tlast marks the final result caused by one input character.
// A character other than end of line is stored in the line buffer; it causes
// no result and the input is ready again at once unless the buffer fills, in
// which case the error byte follows. An end of line on an empty line gives
// the error byte; otherwise it reads the buffered line one character per cycle
// through the buffer's single read port, up to 26 characters, then passes the
// drain and decide states, and the first result is loaded into the output
// register in the emit state once that register is free. A further result
// is loaded in the cycle after the previous one is taken; a line gives at
// most four results, and the input stays busy until the last one is loaded.
// When the receiver stalls, the output register holds its result and the block
// waits; the last result of a line may sit there while the next character is
// accepted. Reset clears the line, restores bitrate index 6, end of line 13 and
// error byte 7, and drops m_tvalid; config writes take effect on the next edge.
module ascii_can_command_line_parser #(
    parameter int LINE_CAPACITY = ascp_pkg::LINE_CAPACITY_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // rx_byte, sink_ok, controller_status
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata,   // reply_byte, frame_id, frame_extended, frame_remote,
                                    // frame_dlc, frame_data, open_mode, open_bitrate
    output logic [1:0]   m_tuser,   // out_kind
    output logic         m_tlast,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [7:0]   cfg_data
);

    ascp_pkg::ascp_cmd_t  cmd;
    ascp_pkg::ascp_stat_t stat;

    logic [7:0]  reply_byte;
    logic [28:0] frame_id;
    logic        frame_extended, frame_remote;
    logic [3:0]  frame_dlc;
    logic [63:0] frame_data;
    logic [1:0]  open_mode;
    logic [3:0]  open_bitrate;

    ascp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ascp_datapath #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .rx_byte           (s_tdata[7:0]),
        .sink_ok           (s_tdata[8]),
        .controller_status (s_tdata[16:9]),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .cmd               (cmd),
        .stat              (stat),
        .m_accept          (m_tvalid && m_tready),
        .m_valid           (m_tvalid),
        .out_kind          (m_tuser),
        .reply_byte        (reply_byte),
        .frame_id          (frame_id),
        .frame_extended    (frame_extended),
        .frame_remote      (frame_remote),
        .frame_dlc         (frame_dlc),
        .frame_data        (frame_data),
        .open_mode         (open_mode),
        .open_bitrate      (open_bitrate),
        .last              (m_tlast)
    );

    assign m_tdata = {7'd0, open_bitrate, open_mode, frame_data, frame_dlc,
                      frame_remote, frame_extended, frame_id, reply_byte};

    a_frame_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ascp_pkg::KIND_FRAME) |-> m_tlast)
        else $error("frame transfer not marked last");

    a_open_close_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == ascp_pkg::KIND_OPEN || m_tuser == ascp_pkg::KIND_CLOSE))
        |-> !m_tlast)
        else $error("open or close transfer marked last");

    a_frame_dlc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ascp_pkg::KIND_FRAME) |-> (frame_dlc <= 4'd8))
        else $error("frame length above eight");

endmodule
